// ----- rtl/rgbhsl_pkg.sv -----
package rgbhsl_pkg;

	// Field widths
	localparam int CH_W  = 8;
	localparam int HUE_W = 15;
	localparam int PCT_W = 13;

	// Output limits
	localparam logic [HUE_W-1:0] HUE_MAX = 15'd23040;
	localparam logic [PCT_W-1:0] PCT_MAX = 13'd6400;

	// Divider geometry: quotient bits retired per stage and stage count
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = 5;
	localparam int QUO_W      = DIV_STEP * DIV_STAGES;
	localparam int NUM_W      = QUO_W + CH_W;

	// Luminance product sum * 3200, sum up to 510
	localparam int LUM_PROD_W = 21;

	// Two front stages, then the divider stages
	localparam int NUM_STAGES = 2 + DIV_STAGES;

	// Front-end result handed to the dividers and the luminance path
	typedef struct packed {
		logic [NUM_W-1:0]      hue_num;
		logic [CH_W-1:0]       hue_den;
		logic [NUM_W-1:0]      sat_num;
		logic [CH_W-1:0]       sat_den;
		logic [LUM_PROD_W-1:0] lum_prod;
		logic                  grey;
	} prep_t;

	// Luminance path result at the last stage
	typedef struct packed {
		logic [PCT_W-1:0] lum;
		logic             grey;
	} lum_out_t;

endpackage

// ----- rtl/rgbhsl_if.sv -----
// Pixel channel: one RGB pixel per transfer
interface rgbhsl_pix_if import rgbhsl_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Result channel: one HSL triple per transfer
interface rgbhsl_hsl_if import rgbhsl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue;
	logic [PCT_W-1:0] saturation;
	logic [PCT_W-1:0] luminance;

	modport source (output valid, output hue, output saturation, output luminance,
		input ready);
	modport sink   (input valid, input hue, input saturation, input luminance,
		output ready);
endinterface

// ----- rtl/rgbhsl_prep.sv -----
// Front end: max/min and hue branch in stage 1, numerators and divisors in stage 2
module rgbhsl_prep import rgbhsl_pkg::*; (
	input  logic            clk,
	input  logic [1:0]      en,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output prep_t           prep
);

	typedef enum logic [1:0] {
		BASE_ZERO,
		BASE_RED_WRAP,
		BASE_GREEN,
		BASE_BLUE
	} hue_base_t;

	logic [CH_W-1:0] mx, mn, mag;
	logic            neg;
	hue_base_t       sel;

	logic [CH_W-1:0] d_s1, mag_s1;
	logic [CH_W:0]   sum_s1;
	logic            neg_s1;
	hue_base_t       sel_s1;

	logic [NUM_W-1:0] base, off;
	prep_t            prep_d;
	prep_t            prep_s2;

	// Max/min and hue branch; ties go to red, then green
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx)  mx = blue;
		if (green < mn) mn = green;
		if (blue < mn)  mn = blue;

		if (red >= green && red >= blue) begin
			if (green >= blue) begin
				sel = BASE_ZERO;
				neg = 1'b0;
				mag = green - blue;
			end else begin
				sel = BASE_RED_WRAP;
				neg = 1'b1;
				mag = blue - green;
			end
		end else if (green >= blue) begin
			sel = BASE_GREEN;
			neg = (blue < red);
			mag = (blue < red) ? red - blue : blue - red;
		end else begin
			sel = BASE_BLUE;
			neg = (red < green);
			mag = (red < green) ? green - red : red - green;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d_s1   <= mx - mn;
			sum_s1 <= {1'b0, mx} + {1'b0, mn};
			sel_s1 <= sel;
			neg_s1 <= neg;
			mag_s1 <= mag;
		end
	end

	// Hue numerator base*d +/- 3840*offset, never negative
	always_comb begin
		case (sel_s1)
			BASE_RED_WRAP: base = NUM_W'(d_s1) * NUM_W'(23040);
			BASE_GREEN:    base = NUM_W'(d_s1) * NUM_W'(7680);
			BASE_BLUE:     base = NUM_W'(d_s1) * NUM_W'(15360);
			default:       base = '0;
		endcase
		off = NUM_W'(mag_s1) * NUM_W'(3840);

		prep_d.hue_num  = neg_s1 ? base - off : base + off;
		prep_d.hue_den  = d_s1;
		prep_d.sat_num  = NUM_W'(d_s1) * NUM_W'(6400);
		prep_d.sat_den  = (sum_s1 <= 9'd255) ? sum_s1[CH_W-1:0]
			: CH_W'(9'd510 - sum_s1);
		prep_d.lum_prod = LUM_PROD_W'(sum_s1) * LUM_PROD_W'(3200);
		prep_d.grey     = (d_s1 == '0);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prep_s2 <= prep_d;
		end
	end

	assign prep = prep_s2;

endmodule

// ----- rtl/rgbhsl_div.sv -----
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
// The quotient must fit in QUO_W bits (dividend < divisor * 2**QUO_W).
module rgbhsl_div import rgbhsl_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [NUM_W-1:0]      num,
	input  logic [CH_W-1:0]       den,
	output logic [QUO_W-1:0]      quo
);

	// Several shift/compare/subtract steps; returns {remainder, quotient bits}
	function automatic logic [CH_W+DIV_STEP-1:0] div_step(
		input logic [CH_W-1:0]     rem,
		input logic [CH_W-1:0]     dv,
		input logic [DIV_STEP-1:0] bits
	);
		logic [CH_W:0]         t;
		logic [CH_W-1:0]       r;
		logic [DIV_STEP-1:0]   q;
		r = rem;
		q = '0;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, dv}) begin
				t    = t - {1'b0, dv};
				q[i] = 1'b1;
			end
			r = t[CH_W-1:0];
		end
		return {r, q};
	endfunction

	logic [CH_W-1:0]  rem_s [DIV_STAGES];
	logic [CH_W-1:0]  den_s [DIV_STAGES];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];
	logic [NUM_W-1:0] num_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam int HI = QUO_W - 1 - DIV_STEP * k;

		logic [CH_W-1:0]          rem_i, den_i;
		logic [QUO_W-1:0]         quo_i, quo_nxt;
		logic [NUM_W-1:0]         num_i;
		logic [CH_W+DIV_STEP-1:0] res;

		if (k == 0) begin : g_first
			assign rem_i = num[NUM_W-1:QUO_W];
			assign den_i = den;
			assign quo_i = '0;
			assign num_i = num;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign quo_i = quo_s[k-1];
			assign num_i = num_s[k-1];
		end

		assign res = div_step(rem_i, den_i, num_i[HI -: DIV_STEP]);

		always_comb begin
			quo_nxt = quo_i;
			quo_nxt[HI -: DIV_STEP] = res[DIV_STEP-1:0];
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= res[CH_W+DIV_STEP-1:DIV_STEP];
				den_s[k] <= den_i;
				quo_s[k] <= quo_nxt;
				num_s[k] <= num_i;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

// ----- rtl/rgbhsl_lum.sv -----
// Luminance: (sum*3200)/255 by reciprocal estimate plus one correction,
// then delayed to line up with the dividers
module rgbhsl_lum import rgbhsl_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [LUM_PROD_W-1:0] lum_prod,
	input  logic                  grey,
	output lum_out_t              res
);

	localparam int EST_W = LUM_PROD_W + 9;

	logic [EST_W-1:0]      est_full;
	logic [PCT_W-1:0]      est_s3;
	logic [LUM_PROD_W-1:0] prod_s3;
	logic                  grey_s3;
	logic [LUM_PROD_W-1:0] rmd;
	logic [PCT_W-1:0]      lum_c;
	lum_out_t              dly_s [DIV_STAGES-1];

	// x*257 >> 16 is floor(x/255) or one less for x below 2**23
	assign est_full = EST_W'(lum_prod) * EST_W'(257);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			est_s3  <= est_full[16 +: PCT_W];
			prod_s3 <= lum_prod;
			grey_s3 <= grey;
		end
	end

	// Correct the estimate by one where the remainder reaches 255
	always_comb begin
		rmd   = prod_s3 - LUM_PROD_W'(est_s3) * LUM_PROD_W'(255);
		lum_c = (rmd >= LUM_PROD_W'(255)) ? est_s3 + 1'b1 : est_s3;
	end

	for (genvar k = 0; k < DIV_STAGES - 1; k++) begin : g_dly
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[1]) begin
					dly_s[0].lum  <= lum_c;
					dly_s[0].grey <= grey_s3;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k+1]) begin
					dly_s[k] <= dly_s[k-1];
				end
			end
		end
	end

	assign res = dly_s[DIV_STAGES-2];

endmodule

// ----- rtl/rgb_to_hsl_converter.sv -----
// RGB to HSL converter. Takes one 8-bit RGB pixel per transfer and returns
// hue in 1/64 degree (0..23040) and saturation and luminance in 1/64 percent
// (0..6400), each truncated toward zero; grey pixels give hue and saturation
// zero. A new pixel is accepted every clock cycle unless every stage is full
// and the output is stalled. Each result passes two front stages (max/min,
// numerators), then five divider stages that retire three quotient bits each.
// Each stage holds its item only while the stage after it is full and
// stalled, so bubbles close up and a held result does not stop the input
// while empty stages remain.
module rgb_to_hsl_converter import rgbhsl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	rgbhsl_pix_if.sink   pix,
	rgbhsl_hsl_if.source hsl
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;
	prep_t                 prep;
	logic [QUO_W-1:0]      hue_quo, sat_quo;
	lum_out_t              lum_res;

	// A stage loads when it is empty or its successor loads
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || hsl.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= pix.valid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign pix.ready = en[0];

	rgbhsl_prep u_prep (
		.clk   (clk),
		.en    (en[1:0]),
		.red   (pix.red),
		.green (pix.green),
		.blue  (pix.blue),
		.prep  (prep)
	);

	rgbhsl_div u_hue_div (
		.clk (clk),
		.en  (en[NUM_STAGES-1:2]),
		.num (prep.hue_num),
		.den (prep.hue_den),
		.quo (hue_quo)
	);

	rgbhsl_div u_sat_div (
		.clk (clk),
		.en  (en[NUM_STAGES-1:2]),
		.num (prep.sat_num),
		.den (prep.sat_den),
		.quo (sat_quo)
	);

	rgbhsl_lum u_lum (
		.clk      (clk),
		.en       (en[NUM_STAGES-1:2]),
		.lum_prod (prep.lum_prod),
		.grey     (prep.grey),
		.res      (lum_res)
	);

	// Grey override and range clamps on the last stage
	assign hsl.valid      = vld_q[NUM_STAGES-1];
	assign hsl.hue        = lum_res.grey ? '0
		: ((hue_quo > QUO_W'(HUE_MAX)) ? HUE_MAX : HUE_W'(hue_quo));
	assign hsl.saturation = lum_res.grey ? '0
		: ((sat_quo > QUO_W'(PCT_MAX)) ? PCT_MAX : PCT_W'(sat_quo));
	assign hsl.luminance  = (lum_res.lum > PCT_MAX) ? PCT_MAX : lum_res.lum;

endmodule

// ----- tb/sv/rgb_to_hsl_converter_tb.sv -----
`timescale 1ns / 100ps

module rgb_to_hsl_converter_tb;
	import rgbhsl_pkg::*;

	// One HSL triple as it leaves the block
	typedef struct {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] lum;
	} hsl_t;

	// Tracks pixels taken by the block and matches the HSL results against them
	class hsl_tracker;
		hsl_t pending_hsl[$];
		int   fails;
		int   checked;

		function new();
			fails   = 0;
			checked = 0;
		endfunction

		// Fixed-point conversion of one pixel
		function hsl_t convert_pixel(logic [CH_W-1:0] r8, logic [CH_W-1:0] g8,
			logic [CH_W-1:0] b8);
			int r, g, b, mx, mn, d, sum, num, den, hue, sat, lum;
			hsl_t res;
			r = int'(r8);
			g = int'(g8);
			b = int'(b8);
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d   = mx - mn;
			sum = mx + mn;
			hue = 0;
			sat = 0;
			lum = (sum * 3200) / 255;
			// grey leaves hue and saturation at zero
			if (d > 0) begin
				// max channel picks the hue sector, ties resolved red first
				if (mx == r) begin
					if (g >= b)
						num = 3840 * (g - b);
					else
						num = 23040 * d - 3840 * (b - g);
				end else if (mx == g) begin
					num = 7680 * d + 3840 * (b - r);
				end else begin
					num = 15360 * d + 3840 * (r - g);
				end
				if (num < 0) num = 0;
				hue = num / d;
				den = (sum <= 255) ? sum : (510 - sum);
				if (den > 0)
					sat = (d * 6400) / den;
			end
			if (hue > int'(HUE_MAX)) hue = int'(HUE_MAX);
			if (sat > int'(PCT_MAX)) sat = int'(PCT_MAX);
			if (lum > int'(PCT_MAX)) lum = int'(PCT_MAX);
			res.hue = hue[HUE_W-1:0];
			res.sat = sat[PCT_W-1:0];
			res.lum = lum[PCT_W-1:0];
			return res;
		endfunction

		function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
			pending_hsl = {pending_hsl, convert_pixel(r, g, b)};
		endfunction

		function void check_result(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
			logic [PCT_W-1:0] lum);
			hsl_t want;
			if (pending_hsl.size() == 0) begin
				$display("%0t: result with no pixel pending: hue %0d sat %0d lum %0d",
					$time, hue, sat, lum);
				fails++;
				return;
			end
			want = pending_hsl.pop_front();
			checked++;
			if (hue !== want.hue) begin
				$display("%0t: hue mismatch, expected %0d actual %0d", $time, want.hue, hue);
				fails++;
			end
			if (sat !== want.sat) begin
				$display("%0t: saturation mismatch, expected %0d actual %0d",
					$time, want.sat, sat);
				fails++;
			end
			if (lum !== want.lum) begin
				$display("%0t: luminance mismatch, expected %0d actual %0d",
					$time, want.lum, lum);
				fails++;
			end
		endfunction

		function int pending();
			return pending_hsl.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   sender_calm;

	hsl_tracker sb = new();

	rgbhsl_pix_if pix ();
	rgbhsl_hsl_if hsl ();

	rgb_to_hsl_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix.sink),
		.hsl    (hsl.source)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Offer one pixel, idling a random cycle at a time ahead of it, and hold it
	// until the transfer
	task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
		while (!sender_calm && $urandom_range(99) < 17) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.red   <= r;
		pix.green <= g;
		pix.blue  <= b;
		do @(posedge clk); while (!pix.ready);
		sb.note_pixel(r, g, b);
	endtask

	function automatic logic [CH_W-1:0] clip_byte(int v);
		if (v < 0) return '0;
		if (v > 255) return 8'd255;
		return v[CH_W-1:0];
	endfunction

	function automatic logic [CH_W-1:0] edge_or_any();
		int pick;
		pick = $urandom_range(2);
		if (pick == 0) return 8'd0;
		if (pick == 1) return 8'd255;
		return CH_W'($urandom_range(255));
	endfunction

	// Result side: check each transfer, random back-pressure, one long hold-off, one stretch of steady ready
	initial begin
		int hold;
		bit pressure_done;
		hold          = 0;
		pressure_done = 0;
		hsl.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hsl.valid && hsl.ready)
				sb.check_result(hsl.hue, hsl.saturation, hsl.luminance);
			if (!pressure_done && sb.checked >= 150) begin
				hold          = 64;
				pressure_done = 1;
			end
			if (hold > 0) begin
				hold--;
				hsl.ready <= 1'b0;
			end else if (sb.checked >= 400 && sb.checked < 500) begin
				hsl.ready <= 1'b1;
			end else begin
				hsl.ready <= ($urandom_range(99) >= 17);
			end
		end
	end

	// Reset, directed pixels, random pixels, drain
	initial begin
		int kind, base, sel, i;
		logic [CH_W-1:0] r, g, b;
		sender_calm = 0;
		arst_n    <= 1'b0;
		pix.valid <= 1'b0;
		pix.red   <= '0;
		pix.green <= '0;
		pix.blue  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// black, white, primaries, max ties and greys
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		// each hue sector, red max with green above and below blue
		send_pixel(8'd200, 8'd50, 8'd10);
		send_pixel(8'd200, 8'd10, 8'd50);
		send_pixel(8'd10, 8'd200, 8'd50);
		send_pixel(8'd50, 8'd200, 8'd10);
		send_pixel(8'd10, 8'd50, 8'd200);
		send_pixel(8'd50, 8'd10, 8'd200);
		// saturation divisor switch around max+min of 255
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd128, 8'd128, 8'd127);
		send_pixel(8'd129, 8'd127, 8'd127);
		// smallest spreads at both ends, then a full-range spread
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd255, 8'd1, 8'd0);

		for (i = 0; i < 600; i++) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				r = CH_W'($urandom_range(255));
				g = CH_W'($urandom_range(255));
				b = CH_W'($urandom_range(255));
			end else if (kind < 75) begin
				// near grey
				base = $urandom_range(255);
				r = clip_byte(base + $urandom_range(6) - 3);
				g = clip_byte(base + $urandom_range(6) - 3);
				b = clip_byte(base + $urandom_range(6) - 3);
			end else if (kind < 90) begin
				// two channels tied
				base = $urandom_range(255);
				sel  = $urandom_range(2);
				r = (sel == 0) ? CH_W'($urandom_range(255)) : CH_W'(base);
				g = (sel == 1) ? CH_W'($urandom_range(255)) : CH_W'(base);
				b = (sel == 2) ? CH_W'($urandom_range(255)) : CH_W'(base);
			end else begin
				r = edge_or_any();
				g = edge_or_any();
				b = edge_or_any();
			end
			sender_calm = (i >= 250 && i < 350);
			send_pixel(r, g, b);
		end
		pix.valid <= 1'b0;

		while (sb.pending() > 0) @(posedge clk);
		repeat (NUM_STAGES + 4) @(posedge clk);
		if (sb.fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
